FILE: sv/four_button_debouncer_assert.svh
// Assertion macros for the four-button debouncer checkers.
`ifndef FOUR_BUTTON_DEBOUNCER_ASSERT_SVH
`define FOUR_BUTTON_DEBOUNCER_ASSERT_SVH

// Clocked check, skipped while reset is asserted.
`define FBD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fbd assertion failed");

// Clocked check that applies only while reset is asserted.
`define FBD_ASSERT_IN_RESET(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) !rst_n |-> prop) \
    else $error("fbd reset assertion failed");

`endif

FILE: sv/fbd_pkg.sv
// Types and constants shared by the four-button debouncer modules.
`default_nettype none

package fbd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESS   = 2'd1,
        PH_HELD    = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        KEY_NONE = 3'd0,
        KEY_OK   = 3'd1,
        KEY_BACK = 3'd2,
        KEY_DOWN = 3'd3,
        KEY_UP   = 3'd4
    } key_t;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_SETTLE = 1'b0
    } reg_idx_t;

    localparam int unsigned SETTLE_W   = 16;
    localparam int unsigned BUTTONS_W  = 4;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd500;

    // button bits in the down mask
    localparam int unsigned BTN_BACK = 0;
    localparam int unsigned BTN_OK   = 2;
    localparam int unsigned BTN_UP   = 3;

    typedef struct packed {
        logic valid;
        key_t key;
    } result_t;

    function automatic key_t pick_key(input logic [BUTTONS_W-1:0] down);
        key_t k;
        if (down[BTN_OK])
            k = KEY_OK;
        else if (down[BTN_BACK])
            k = KEY_BACK;
        else if (down[BTN_UP])
            k = KEY_UP;
        else
            k = KEY_DOWN;
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: sv/fbd_cfg.sv
// APB register file holding the settle time.
`default_nettype none

module fbd_cfg
    import fbd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output logic      [SETTLE_W-1:0] settle_ticks
);

    logic [SETTLE_W-1:0] settle_ticks_reg;
    logic [SETTLE_W-1:0] settle_ticks_next;
    logic                wr_en;
    reg_idx_t            idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb
    begin
        settle_ticks_next = settle_ticks_reg;
        if (wr_en && idx == REG_SETTLE)
            settle_ticks_next = pwdata[SETTLE_W-1:0];
    end

    always_comb
    begin
        unique case (idx)
            REG_SETTLE: prdata = {{(32-SETTLE_W){1'b0}}, settle_ticks_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_ticks_reg <= SETTLE_RESET;
        else
            settle_ticks_reg <= settle_ticks_next;
    end

    assign settle_ticks = settle_ticks_reg;

endmodule

`default_nettype wire

FILE: sv/fbd_core.sv
// Debounce state machine and latched key, updated once per accepted request.
`default_nettype none

module fbd_core
    import fbd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire logic                 command,
    input  wire logic [BUTTONS_W-1:0] buttons_n,
    input  wire logic [SETTLE_W-1:0]  settle_ticks,
    output result_t                   result
);

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [SETTLE_W-1:0] count_reg;
    logic [SETTLE_W-1:0] count_next;
    key_t                key_reg;
    key_t                key_next;

    logic [BUTTONS_W-1:0] down;
    logic                 any;
    logic                 tick;
    logic                 rd;
    logic [SETTLE_W-1:0]  count_dec;
    logic                 expire;

    assign down      = ~buttons_n;
    assign any       = |down;
    assign tick      = req_valid && cmd_t'(command) == CMD_TICK;
    assign rd        = req_valid && cmd_t'(command) == CMD_READ;
    assign count_dec = count_reg - 1'b1;
    assign expire    = count_dec == '0;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (tick)
        begin
            unique case (phase_reg)
                PH_IDLE:    if (any) phase_next = PH_PRESS;
                PH_PRESS:   if (expire) phase_next = any ? PH_HELD : PH_IDLE;
                PH_HELD:    if (!any) phase_next = PH_RELEASE;
                PH_RELEASE: if (expire) phase_next = PH_IDLE;
                default:    phase_next = PH_IDLE;
            endcase
        end
    end

    // counter, key latch and result
    always_comb
    begin
        count_next = count_reg;
        key_next   = key_reg;
        result     = '{valid: req_valid, key: KEY_NONE};
        if (tick)
        begin
            unique case (phase_reg)
                PH_IDLE:
                    if (any) count_next = settle_ticks;
                PH_PRESS:
                begin
                    count_next = count_dec;
                    if (expire && any)
                        key_next = pick_key(down);
                end
                PH_HELD:
                    if (!any) count_next = settle_ticks;
                PH_RELEASE:
                    count_next = count_dec;
                default:
                    count_next = count_reg;
            endcase
        end
        else if (rd)
        begin
            result.key = key_reg;
            key_next   = KEY_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            key_reg   <= KEY_NONE;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            key_reg   <= key_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/fbd_obuf.sv
// Two-entry result buffer between the state machine and the output stream.
`default_nettype none

module fbd_obuf
    import fbd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  result_t      result,
    output logic         room,
    output logic         out_valid,
    input  wire logic    out_ready,
    output key_t         out_key
);

    key_t       mem [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic       push;
    logic       pop;

    assign room      = ~count_reg[1];
    assign out_valid = count_reg != 2'd0;
    assign out_key   = mem[rd_ptr_reg];
    assign push      = result.valid;
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= result.key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/four_button_debouncer.sv
// Four-button debouncer: stream requests in, one key result out per request.
// Each result is registered in a two-entry result buffer and presented on m_axis from it.
// Throughput: one request per cycle while that buffer has room; it keeps s_axis_tready
// high while one result waits, so a stall costs nothing until two results queue.
// Reset (async, active low): phase idle, count 0, no key latched, settle time 500,
// result buffer empty.
`default_nettype none

module four_button_debouncer
    import fbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [3:0] buttons_n, [7:4] zero
    input  wire logic        s_axis_tuser,   // [0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,   // [2:0] key, [7:3] zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [SETTLE_W-1:0] settle_ticks;
    result_t             result;
    key_t                out_key;
    logic                accept;

    assign accept = s_axis_tvalid & s_axis_tready;

    fbd_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .settle_ticks (settle_ticks)
    );

    fbd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (accept),
        .command      (s_axis_tuser),
        .buttons_n    (s_axis_tdata[BUTTONS_W-1:0]),
        .settle_ticks (settle_ticks),
        .result       (result)
    );

    fbd_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .room      (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_key   (out_key)
    );

    assign m_axis_tdata = {5'd0, out_key};

endmodule

`default_nettype wire

FILE: sv/fbd_checker.sv
// Port-level checker for the four-button debouncer, bound to the top level.
`default_nettype none

`include "four_button_debouncer_assert.svh"

module fbd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic [31:0] prdata
);

    `FBD_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    `FBD_ASSERT(a_key_range, clk, rst_n, m_axis_tvalid |-> m_axis_tdata[7:3] == 5'd0 && m_axis_tdata[2:0] <= 3'd4)
    `FBD_ASSERT(a_empty_accepts, clk, rst_n, !m_axis_tvalid |-> s_axis_tready)
    `FBD_ASSERT(a_prdata_width, clk, rst_n, prdata[31:16] == 16'd0)
    `FBD_ASSERT_IN_RESET(a_reset_empty, clk, rst_n, !m_axis_tvalid)

endmodule

bind four_button_debouncer fbd_checker u_fbd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .prdata        (prdata)
);

`default_nettype wire
